// File: hdl/ddo_pkg.sv
package ddo_pkg;

  localparam int TICK_BITS    = 12;
  localparam int CORDIC_STEPS = 16;

  localparam int DPT_W     = 24;
  localparam int GAIN_W    = 32;
  localparam int GAIN_FRAC = 24;
  localparam int POS_W     = 48;
  localparam int HEAD_W    = 32;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 32;

  localparam logic [DPT_W-1:0]  DPT_RESET  = DPT_W'(3384434);
  localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(18164478);

  localparam logic [CFG_IDX_W-1:0] CFG_DISTANCE_PER_TICK = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_HEADING_GAIN      = CFG_IDX_W'(1);

  // CORDIC
  localparam int CORDIC_W   = 34;
  localparam int STEP_W     = $clog2(CORDIC_STEPS);
  localparam int ATAN_N     = 32;
  localparam int ATAN_IDX_W = 5;
  localparam int ATAN_W     = 30;
  localparam logic signed [CORDIC_W-1:0] CORDIC_K = CORDIC_W'(652032874);

  localparam logic [ATAN_W-1:0] ATAN_TURNS [ATAN_N] = '{
    30'h20000000, 30'h12E4051E, 30'h09FB385B, 30'h051111D4, 30'h028B0D43, 30'h0145D7E1,
    30'h00A2F61E, 30'h00517C55, 30'h0028BE53, 30'h00145F2F, 30'h000A2F98, 30'h000517CC,
    30'h00028BE6, 30'h000145F3, 30'h0000A2FA, 30'h0000517D, 30'h000028BE, 30'h0000145F,
    30'h00000A30, 30'h00000518, 30'h0000028C, 30'h00000146, 30'h000000A3, 30'h00000051,
    30'h00000029, 30'h00000014, 30'h0000000A, 30'h00000005, 30'h00000003, 30'h00000001,
    30'h00000001, 30'h00000000
  };

  // distance and position arithmetic
  localparam int DIST_W  = TICK_BITS + DPT_W;
  localparam int SUM_W   = DIST_W + 1;
  localparam int LO_W    = 16;
  localparam int HI_W    = SUM_W - LO_W;
  localparam int XHI_W   = HI_W + 1 + CORDIC_W;
  localparam int XLO_W   = LO_W + 1 + CORDIC_W;
  localparam int ACC_W   = XHI_W + 1;
  localparam int ACC_SH  = 15;
  localparam int DX_W    = ACC_W - ACC_SH;
  localparam int PS_W    = ((DX_W > POS_W) ? DX_W : POS_W) + 1;

  // heading arithmetic
  localparam int DIFF_W  = DIST_W + 1;
  localparam int DHI_W   = DIFF_W - GAIN_FRAC;
  localparam int HHP_W   = DHI_W + GAIN_W + 1;
  localparam int HLP_W   = GAIN_FRAC + GAIN_W;

  localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
  localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ROTATE,
    ST_FIX,
    ST_MUL,
    ST_SUM,
    ST_UPDATE
  } ctrl_state_e;

  typedef struct packed {
    logic accept;
    logic load;
    logic rotate;
    logic fix;
    logic mul;
    logic sum;
    logic update;
  } dp_cmd_t;

  typedef struct packed {
    logic last_step;
    logic out_free;
  } dp_sts_t;

  function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [PS_W-1:0] v);
    logic signed [POS_W-1:0] r;
    if (v > PS_W'(POS_MAX)) begin
      r = POS_MAX;
    end else if (v < PS_W'(POS_MIN)) begin
      r = POS_MIN;
    end else begin
      r = POS_W'(v);
    end
    return r;
  endfunction

endpackage

// File: hdl/ddo_in_if.sv
interface ddo_in_if;
  import ddo_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [TICK_BITS-1:0] left_ticks;
  logic [TICK_BITS-1:0] right_ticks;
  logic                 restart;

  modport source (output valid, left_ticks, right_ticks, restart, input ready);
  modport sink (input valid, left_ticks, right_ticks, restart, output ready);
endinterface

// File: hdl/ddo_out_if.sv
interface ddo_out_if;
  import ddo_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [POS_W-1:0]  pos_x;
  logic signed [POS_W-1:0]  pos_y;
  logic [HEAD_W-1:0]        heading_angle;

  modport source (output valid, pos_x, pos_y, heading_angle, input ready);
  modport sink (input valid, pos_x, pos_y, heading_angle, output ready);
endinterface

// File: hdl/differential_drive_odometry.sv
// Dead-reckoning odometry for a differential-drive robot. Each input item carries one sample
// period's left and right encoder tick counts and a restart flag; each produces one result with
// the updated x, y position (signed Q15.32 metres, saturating) and heading (binary angle, 2^32
// is one turn). Position moves along the heading held before the sample, then heading turns
// by the wheel distance difference times heading_gain. One item is processed at a time: after
// accepting an item the controller steps through load, rotate, fix, multiply, sum and update
// and accepts the next item only once back in idle. The iterative sine/cosine CORDIC does one
// rotation per cycle. A result waiting at the output holds the block in its final step until
// taken. Write distance_per_tick and heading_gain only while no item is in flight.
module differential_drive_odometry (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [ddo_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [ddo_pkg::CFG_DATA_W-1:0] cfg_data_i,
  ddo_in_if.sink                         in_ch,
  ddo_out_if.source                      out_ch
);
  import ddo_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  ddo_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_ch.valid),
    .in_ready_o (in_ch.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ddo_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .left_ticks_i    (in_ch.left_ticks),
    .right_ticks_i   (in_ch.right_ticks),
    .restart_i       (in_ch.restart),
    .out_ready_i     (out_ch.ready),
    .out_valid_o     (out_ch.valid),
    .pos_x_o         (out_ch.pos_x),
    .pos_y_o         (out_ch.pos_y),
    .heading_angle_o (out_ch.heading_angle),
    .cmd_i           (cmd),
    .sts_o           (sts)
  );

endmodule

// File: hdl/ddo_ctrl.sv
module ddo_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  ddo_pkg::dp_sts_t  sts_i,
  output ddo_pkg::dp_cmd_t  cmd_o
);
  import ddo_pkg::*;

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_LOAD;
      end
      ST_LOAD:   state_d = ST_ROTATE;
      ST_ROTATE: begin
        if (sts_i.last_step) state_d = ST_FIX;
      end
      ST_FIX:    state_d = ST_MUL;
      ST_MUL:    state_d = ST_SUM;
      ST_SUM:    state_d = ST_UPDATE;
      ST_UPDATE: begin
        if (sts_i.out_free) state_d = ST_IDLE;
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
      end
      ST_LOAD:   cmd_o.load   = 1'b1;
      ST_ROTATE: cmd_o.rotate = 1'b1;
      ST_FIX:    cmd_o.fix    = 1'b1;
      ST_MUL:    cmd_o.mul    = 1'b1;
      ST_SUM:    cmd_o.sum    = 1'b1;
      ST_UPDATE: cmd_o.update = sts_i.out_free;
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

// File: hdl/ddo_datapath.sv
module ddo_datapath (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [ddo_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [ddo_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic [ddo_pkg::TICK_BITS-1:0]      left_ticks_i,
  input  logic [ddo_pkg::TICK_BITS-1:0]      right_ticks_i,
  input  logic                               restart_i,
  input  logic                               out_ready_i,
  output logic                               out_valid_o,
  output logic signed [ddo_pkg::POS_W-1:0]   pos_x_o,
  output logic signed [ddo_pkg::POS_W-1:0]   pos_y_o,
  output logic [ddo_pkg::HEAD_W-1:0]         heading_angle_o,
  input  ddo_pkg::dp_cmd_t                   cmd_i,
  output ddo_pkg::dp_sts_t                   sts_o
);
  import ddo_pkg::*;

  logic [DPT_W-1:0]  dpt_q;
  logic [GAIN_W-1:0] gain_q;

  logic [HEAD_W-1:0]       heading_q;
  logic signed [POS_W-1:0] pos_x_q;
  logic signed [POS_W-1:0] pos_y_q;
  logic                    out_valid_q;

  logic [TICK_BITS-1:0] left_q, right_q;
  logic [DIST_W-1:0]    dl_q, dr_q;

  logic signed [CORDIC_W-1:0] x_q, y_q, z_q;
  logic                       flip_q;
  logic [STEP_W-1:0]          step_q;

  logic signed [CORDIC_W-1:0] cos_q, sin_q;
  logic [SUM_W-1:0]           sum_q;
  logic signed [DIFF_W-1:0]   diff_q;

  logic signed [XHI_W-1:0] xhi_q, yhi_q;
  logic signed [XLO_W-1:0] xlo_q, ylo_q;
  logic [HEAD_W-1:0]       hhi_q, hlo_q;

  logic signed [DX_W-1:0]  dx_q, dy_q;

  logic signed [POS_W-1:0] out_x_q, out_y_q;
  logic [HEAD_W-1:0]       out_h_q;

  logic                       flip;
  logic [HEAD_W-1:0]          z_init;
  logic signed [CORDIC_W-1:0] xs, ys, atan;
  logic signed [HI_W:0]       sum_hi;
  logic signed [LO_W:0]       sum_lo;
  logic signed [DHI_W-1:0]    dhi;
  logic [GAIN_FRAC-1:0]       dlo;
  logic signed [HHP_W-1:0]    hhi_prod;
  logic [HLP_W-1:0]           hlo_prod;
  logic signed [ACC_W-1:0]    acc_x, acc_y;
  logic signed [PS_W-1:0]     px_sum, py_sum;
  logic signed [POS_W-1:0]    px_new, py_new;

  assign flip   = heading_q[HEAD_W-1] ^ heading_q[HEAD_W-2];
  assign z_init = {heading_q[HEAD_W-1] ^ flip, heading_q[HEAD_W-2:0]};
  assign xs     = x_q >>> step_q;
  assign ys     = y_q >>> step_q;
  assign atan   = $signed(CORDIC_W'(ATAN_TURNS[ATAN_IDX_W'(step_q)]));

  assign sum_hi   = $signed({1'b0, sum_q[SUM_W-1:LO_W]});
  assign sum_lo   = $signed({1'b0, sum_q[LO_W-1:0]});
  assign dhi      = diff_q[DIFF_W-1:GAIN_FRAC];
  assign dlo      = diff_q[GAIN_FRAC-1:0];
  assign hhi_prod = dhi * $signed({1'b0, gain_q});
  assign hlo_prod = HLP_W'(dlo) * HLP_W'(gain_q);

  assign acc_x = ACC_W'(xhi_q) + ACC_W'(xlo_q >>> LO_W);
  assign acc_y = ACC_W'(yhi_q) + ACC_W'(ylo_q >>> LO_W);

  assign px_sum = PS_W'(pos_x_q) + PS_W'(dx_q);
  assign py_sum = PS_W'(pos_y_q) + PS_W'(dy_q);
  assign px_new = sat_pos(px_sum);
  assign py_new = sat_pos(py_sum);

  assign sts_o.last_step = (step_q == STEP_W'(CORDIC_STEPS - 1));
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dpt_q  <= DPT_RESET;
      gain_q <= GAIN_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_DISTANCE_PER_TICK: dpt_q  <= cfg_data_i[DPT_W-1:0];
        CFG_HEADING_GAIN:      gain_q <= cfg_data_i[GAIN_W-1:0];
        default: begin
          dpt_q <= dpt_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heading_q   <= '0;
      pos_x_q     <= '0;
      pos_y_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.accept && restart_i) begin
        heading_q <= '0;
        pos_x_q   <= '0;
        pos_y_q   <= '0;
      end
      if (cmd_i.sum) begin
        heading_q <= heading_q + hhi_q + hlo_q;
      end
      if (cmd_i.update) begin
        pos_x_q <= px_new;
        pos_y_q <= py_new;
      end
      if (cmd_i.update) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      left_q  <= left_ticks_i;
      right_q <= right_ticks_i;
    end
    if (cmd_i.load) begin
      dl_q   <= DIST_W'(left_q) * DIST_W'(dpt_q);
      dr_q   <= DIST_W'(right_q) * DIST_W'(dpt_q);
      x_q    <= CORDIC_K;
      y_q    <= '0;
      z_q    <= CORDIC_W'($signed(z_init));
      flip_q <= flip;
      step_q <= '0;
    end
    if (cmd_i.rotate) begin
      if (!z_q[CORDIC_W-1]) begin
        x_q <= x_q - ys;
        y_q <= y_q + xs;
        z_q <= z_q - atan;
      end else begin
        x_q <= x_q + ys;
        y_q <= y_q - xs;
        z_q <= z_q + atan;
      end
      step_q <= step_q + STEP_W'(1);
    end
    if (cmd_i.fix) begin
      cos_q  <= flip_q ? -x_q : x_q;
      sin_q  <= flip_q ? -y_q : y_q;
      sum_q  <= SUM_W'(dl_q) + SUM_W'(dr_q);
      diff_q <= $signed(DIFF_W'(dl_q)) - $signed(DIFF_W'(dr_q));
    end
    if (cmd_i.mul) begin
      xhi_q <= sum_hi * cos_q;
      xlo_q <= sum_lo * cos_q;
      yhi_q <= sum_hi * sin_q;
      ylo_q <= sum_lo * sin_q;
      hhi_q <= hhi_prod[HEAD_W-1:0];
      hlo_q <= hlo_prod[GAIN_FRAC+HEAD_W-1:GAIN_FRAC];
    end
    if (cmd_i.sum) begin
      dx_q <= DX_W'(acc_x >>> ACC_SH);
      dy_q <= DX_W'(acc_y >>> ACC_SH);
    end
    if (cmd_i.update) begin
      out_x_q <= px_new;
      out_y_q <= py_new;
      out_h_q <= heading_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign pos_x_o         = out_x_q;
  assign pos_y_o         = out_y_q;
  assign heading_angle_o = out_h_q;

endmodule

// File: hdl/ddo_checker.sv
module ddo_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_ready_i,
  input logic                           out_valid_i,
  input logic                           out_ready_i,
  input logic signed [ddo_pkg::POS_W-1:0] pos_x_i,
  input logic signed [ddo_pkg::POS_W-1:0] pos_y_i,
  input logic [ddo_pkg::HEAD_W-1:0]     heading_angle_i
);
  import ddo_pkg::*;

  assert property (@(posedge clk_i) !rst_ni |-> !out_valid_i && in_ready_i)
    else $error("reset must leave block idle with no result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("second item taken while one is in flight");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> !$past(in_ready_i))
    else $error("result appeared while block was idle");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable(pos_x_i) && $stable(pos_y_i) && $stable(heading_angle_i))
    else $error("stalled result changed");

endmodule

bind differential_drive_odometry ddo_checker u_ddo_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_ch.valid),
  .in_ready_i      (in_ch.ready),
  .out_valid_i     (out_ch.valid),
  .out_ready_i     (out_ch.ready),
  .pos_x_i         (out_ch.pos_x),
  .pos_y_i         (out_ch.pos_y),
  .heading_angle_i (out_ch.heading_angle)
);
